FILE: rtl/core/radial_field_interpolator_top_defines.svh
// assertion macros shared by the checker
`ifndef RADIAL_FIELD_INTERPOLATOR_TOP_DEFINES_SVH
`define RADIAL_FIELD_INTERPOLATOR_TOP_DEFINES_SVH

// property that must hold in the cycle after a trigger
`define RFI_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("check failed");

// property that must hold in the same cycle as a trigger
`define RFI_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("check failed");

`endif

FILE: rtl/core/rfi_pkg.sv
// shared types and constants for the radial field interpolator
package rfi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned CntW  = 9;

  // table depth, matched to the 8-bit point index and the 9-bit count
  localparam int unsigned MaxPoints = 256;

  // operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  // register index
  localparam logic RegPointCount = 1'b0;

  // one beat between front and back
  typedef struct packed {
    logic                    op;
    logic [IdxW-1:0]         point_index;
    logic signed [DataW-1:0] grid_rho;
    logic signed [DataW-1:0] grid_gradient;
    logic signed [DataW-1:0] query_rho;
    logic signed [DataW-1:0] grad_r;
    logic signed [DataW-1:0] grad_phi;
    logic signed [DataW-1:0] grad_z;
  } item_t;

  // one result beat
  typedef struct packed {
    logic signed [DataW-1:0] field_r;
    logic signed [DataW-1:0] field_phi;
    logic signed [DataW-1:0] field_z;
    logic                    in_range;
  } result_t;

  // saturate a 64-bit value to 32 bits signed
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sh0000_0000_7FFF_FFFF;
    lo_lim = -64'sh0000_0000_8000_0000;
    if (x > hi_lim) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo_lim) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[DataW-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/rfi_fifo.sv
// short queue of items between the front and the back
module rfi_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  rfi_pkg::item_t wdata,
  output logic           full,
  input  logic           rd,
  output rfi_pkg::item_t rdata,
  output logic           empty
);
  import rfi_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t             slots [Depth];
  logic [AW-1:0]     wp;
  logic [AW-1:0]     rp;
  logic [AW:0]       cnt;

  assign full  = (cnt == (AW+1)'(Depth));
  assign empty = (cnt == '0);
  assign rdata = slots[rp];

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        slots[wp] <= wdata;
        wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      end
      if (rd && !empty) begin
        rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

FILE: rtl/core/rfi_back.sv
// back end: table store, interval search, divider, multiplies
module rfi_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [rfi_pkg::CntW-1:0] point_count,
  input  logic                   item_valid,
  input  rfi_pkg::item_t         item,
  output logic                   item_take,
  output logic                   res_valid,
  output rfi_pkg::result_t       res,
  input  logic                   res_take
);
  import rfi_pkg::*;

  localparam int unsigned AW = $clog2(MaxPoints);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LO, S_RD_HI, S_CHECK, S_SCAN, S_RD_IV, S_IV, S_DIV,
    S_RD_GR, S_INTERP, S_MUL, S_DONE
  } state_t;

  state_t state;

  logic signed [DataW-1:0] rho_mem  [MaxPoints];
  logic signed [DataW-1:0] grad_mem [MaxPoints];
  logic [AW-1:0]           raddr;
  logic signed [DataW-1:0] rho_q;
  logic signed [DataW-1:0] grad_q;

  item_t                   cur;
  logic [AW:0]             n;
  logic signed [DataW-1:0] lo_v;
  logic [AW:0]             j;
  logic [AW-1:0]           iv;
  logic signed [DataW-1:0] r0;
  logic signed [DataW-1:0] g0;
  logic [1:0]              phase;
  logic signed [33:0]      num;
  logic signed [33:0]      den;
  logic [49:0]             dividend;
  logic [34:0]             rem;
  logic [49:0]             quo;
  logic [5:0]              bitc;
  logic [16:0]             t;
  logic signed [DataW-1:0] dv;
  logic signed [63:0]      prod;
  logic [1:0]              mi;
  result_t                 out;
  logic                    out_valid;

  logic [AW:0]             n_clamp;
  logic [34:0]             rem_sh;
  logic signed [DataW-1:0] comp;

  // clamp the point count
  always_comb begin
    if (point_count < CntW'(2)) begin
      n_clamp = (AW+1)'(2);
    end else if (point_count > CntW'(MaxPoints)) begin
      n_clamp = (AW+1)'(MaxPoints);
    end else begin
      n_clamp = (AW+1)'(point_count);
    end
  end

  // component for the shared multiplier
  always_comb begin
    case (mi)
      2'd0:    comp = cur.grad_r;
      2'd1:    comp = cur.grad_phi;
      default: comp = cur.grad_z;
    endcase
  end

  assign rem_sh    = {rem[33:0], dividend[49]};
  assign item_take = (state == S_IDLE) && item_valid && !out_valid;
  assign res_valid = out_valid;
  assign res       = out;

  // table memories, one read port each
  always_ff @(posedge clk) begin
    if (item_take && item.op == OpLoad) begin
      rho_mem[item.point_index[AW-1:0]]  <= item.grid_rho;
      grad_mem[item.point_index[AW-1:0]] <= item.grid_gradient;
    end
    rho_q  <= rho_mem[raddr];
    grad_q <= grad_mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      raddr     <= '0;
    end else begin
      if (res_take && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_take && item.op == OpEval) begin
            cur   <= item;
            n     <= n_clamp;
            raddr <= '0;
            state <= S_RD_LO;
          end
        end
        S_RD_LO: begin
          raddr <= AW'(n - 1'b1);
          state <= S_RD_HI;
        end
        S_RD_HI: begin
          lo_v  <= rho_q;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cur.query_rho < lo_v || cur.query_rho > rho_q) begin
            out       <= '0;
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            j     <= (AW+1)'(1);
            raddr <= AW'(1);
            state <= S_SCAN;
            phase <= 2'd0;
          end
        end
        S_SCAN: begin
          // one entry at a time through the registered read port: wait for the read, then compare
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else if (j >= n - 1'b1 || rho_q > cur.query_rho) begin
            iv    <= AW'(j - 1'b1);
            raddr <= AW'(j - 1'b1);
            phase <= 2'd0;
            state <= S_RD_IV;
          end else begin
            j     <= j + 1'b1;
            raddr <= AW'(j + 1'b1);
            phase <= 2'd0;
          end
        end
        S_RD_IV: begin
          raddr <= iv + 1'b1;
          state <= S_IV;
          phase <= 2'd0;
        end
        S_IV: begin
          if (phase == 2'd0) begin
            r0    <= rho_q;
            g0    <= grad_q;
            phase <= 2'd1;
          end else begin
            num      <= 34'(cur.query_rho) - 34'(r0);
            den      <= 34'(rho_q) - 34'(r0);
            dividend <= {34'(cur.query_rho) - 34'(r0), 16'd0};
            rem      <= '0;
            quo      <= '0;
            bitc     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (den <= 0 || num <= 0) begin
            t     <= '0;
            state <= S_RD_GR;
          end else if (bitc == 6'd50) begin
            t     <= (quo > 50'd65536) ? 17'd65536 : quo[16:0];
            state <= S_RD_GR;
          end else begin
            if (rem_sh >= 35'(den)) begin
              rem <= rem_sh - 35'(den);
              quo <= {quo[48:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[48:0], 1'b0};
            end
            dividend <= {dividend[48:0], 1'b0};
            bitc     <= bitc + 1'b1;
          end
        end
        S_RD_GR: begin
          prod  <= $signed({1'b0, t}) * (64'(grad_q) - 64'(g0));
          state <= S_INTERP;
        end
        S_INTERP: begin
          // interpolated gradient lies between the two table gradients
          dv    <= DataW'(64'(g0) + (prod >>> FracW));
          mi    <= 2'd0;
          state <= S_MUL;
          phase <= 2'd0;
        end
        S_MUL: begin
          // one multiply per component, then shift and saturate
          if (phase == 2'd0) begin
            prod  <= 64'(dv) * 64'(comp);
            phase <= 2'd1;
          end else begin
            case (mi)
              2'd0:    out.field_r   <= sat32(prod >>> FracW);
              2'd1:    out.field_phi <= sat32(prod >>> FracW);
              default: out.field_z   <= sat32(prod >>> FracW);
            endcase
            phase <= 2'd0;
            if (mi == 2'd2) begin
              out.in_range <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_DONE;
            end else begin
              mi <= mi + 1'b1;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/radial_field_interpolator_top.sv
// Radial field interpolator. Load beats (op 0) write one grid point and return
// nothing; evaluate beats (op 1) return one field result. The back end takes a
// beat only while no result waits, so a result that is not popped holds back
// every later beat. Load beats are written into the table as the back end takes
// them. An evaluate beat runs the interval search, which scans grid points one
// at a time through its single registered read port, then the one-bit-per-cycle
// divider, which stops without dividing when the query sits on the interval
// start or the interval is empty. A query outside the profile returns a zero
// result with in_range low, without the search. A two-entry queue decouples the
// input side from the evaluator.
module radial_field_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  point_index,
  input  logic signed [31:0] grid_rho,
  input  logic signed [31:0] grid_gradient,
  input  logic signed [31:0] query_rho,
  input  logic signed [31:0] grad_r,
  input  logic signed [31:0] grad_phi,
  input  logic signed [31:0] grad_z,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] field_r,
  output logic signed [31:0] field_phi,
  output logic signed [31:0] field_z,
  output logic        in_range
);
  import rfi_pkg::*;

  logic [CntW-1:0] point_count;
  item_t           in_item;
  item_t           q_item;
  logic            q_empty;
  logic            q_take;
  result_t         res;
  logic            res_valid;

  assign pready = 1'b1;
  assign prdata = (paddr == RegPointCount) ? {23'd0, point_count} : 32'd0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CntW'(2);
    end else if (psel && penable && pwrite && paddr == RegPointCount) begin
      point_count <= pwdata[CntW-1:0];
    end
  end

  // front: pack and drop loads beyond the table
  always_comb begin
    in_item = '{op: op, point_index: point_index, grid_rho: grid_rho,
                grid_gradient: grid_gradient, query_rho: query_rho,
                grad_r: grad_r, grad_phi: grad_phi, grad_z: grad_z};
  end

  rfi_fifo #(.Depth(2)) u_fifo (
    .clk(clk), .rst(rst),
    .wr(push && (op == OpEval || 32'(point_index) < MaxPoints)),
    .wdata(in_item), .full(full),
    .rd(q_take), .rdata(q_item), .empty(q_empty)
  );

  rfi_back u_back (
    .clk(clk), .rst(rst), .point_count(point_count),
    .item_valid(!q_empty), .item(q_item), .item_take(q_take),
    .res_valid(res_valid), .res(res), .res_take(pop)
  );

  assign empty     = !res_valid;
  assign field_r   = res.field_r;
  assign field_phi = res.field_phi;
  assign field_z   = res.field_z;
  assign in_range  = res.in_range;

endmodule

FILE: rtl/core/rfi_checker.sv
// port-level checks for the radial field interpolator
`include "radial_field_interpolator_top_defines.svh"

module rfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        in_range,
  input logic [31:0] field_r,
  input logic [31:0] field_phi,
  input logic [31:0] field_z,
  input logic        pready
);
  // a waiting result beat holds until popped
  `RFI_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(field_r))
  // out of range results carry zero field
  `RFI_ASSERT_NOW(a_zero, clk, rst, !empty && !in_range, field_r == 0 && field_phi == 0 && field_z == 0)
  // config port never stalls
  `RFI_ASSERT_NOW(a_ready, clk, rst, 1'b1, pready)
endmodule

bind radial_field_interpolator_top rfi_checker u_rfi_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .in_range(in_range),
  .field_r(field_r), .field_phi(field_phi), .field_z(field_z), .pready(pready)
);
